>>> rtl/sqlv_pkg.sv
// Shared types, constants and helper functions for the sprite quad vertex setup block.
// No dependencies; imported by sqlv_div_lane and sprite_quad_list_vertices.
package sqlv_pkg;

  // Default sine table size (log2 of entries over a full turn)
  localparam int SINE_BITS_DEFAULT = 10;

  // One full turn in 1/64 degree units
  localparam int FULL_TURN = 23040;

  // Quotient bits produced by each divider lane; larger results saturate anyway
  localparam int QUO_BITS = 17;

  // Divider lane widths: x/y lanes divide Q.19 sums by 16*viewport, u/v lanes divide texels*256
  localparam int XY_NUM_W = 34;
  localparam int XY_DEN_W = 19;
  localparam int UV_NUM_W = 25;
  localparam int UV_DEN_W = 15;

  // Vertex slot of the sixth vertex
  localparam logic [2:0] LAST_SLOT = 3'd5;

  // Register reset values
  localparam logic [14:0] VIEWPORT_WIDTH_RST  = 15'd1280;
  localparam logic [14:0] VIEWPORT_HEIGHT_RST = 15'd720;
  localparam logic [14:0] TEXTURE_WIDTH_RST   = 15'd256;
  localparam logic [14:0] TEXTURE_HEIGHT_RST  = 15'd256;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_VIEWPORT_WIDTH  = 4'd0,
    REG_VIEWPORT_HEIGHT = 4'd1,
    REG_TEXTURE_WIDTH   = 4'd2,
    REG_TEXTURE_HEIGHT  = 4'd3
  } cfg_reg_t;

  // Per-vertex geometry carried through the front of the pipeline
  typedef struct packed {
    logic signed [16:0] ox;
    logic signed [16:0] oy;
    logic signed [17:0] cx5;
    logic signed [17:0] cy5;
    logic signed [24:0] un;
    logic signed [24:0] vn;
  } geo_t;

  // Sideband that rides along with every vertex
  typedef struct packed {
    logic [31:0] color;
    logic [2:0]  slot;
    logic        last;
  } side_t;

  // Corner for each vertex slot: triangles 0,1,2 and 2,1,3
  function automatic logic [1:0] corner_of(input logic [2:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Rebuild a signed quotient from a divider lane; overflow stands in as +/- 2^QUO_BITS
  function automatic logic signed [QUO_BITS+1:0] signed_quo(input logic [QUO_BITS-1:0] q,
                                                            input logic neg,
                                                            input logic ovf);
    logic signed [QUO_BITS+1:0] m;
    m = ovf ? ((QUO_BITS+2)'(1) <<< QUO_BITS) : $signed({2'b00, q});
    return neg ? -m : m;
  endfunction

  // Clamp to 16-bit signed
  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > 32'sd32767) r = 16'h7fff;
    else if (v < -32'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

>>> rtl/sqlv_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage, rounding to nearest.
// Depends on sqlv_pkg (QUO_BITS). Setup and bit stages advance only while en is high.
module sqlv_div_lane #(
  parameter int NUM_W = sqlv_pkg::XY_NUM_W,
  parameter int DEN_W = sqlv_pkg::XY_DEN_W
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]            den,
  output logic [sqlv_pkg::QUO_BITS-1:0] quo,
  output logic                        neg,
  output logic                        ovf
);
  import sqlv_pkg::*;

  localparam int QB    = QUO_BITS;
  localparam int MAG_W = NUM_W + 1;
  localparam int HI_W  = MAG_W - QB;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic signed [MAG_W-1:0] num_ext;
  logic [MAG_W-1:0]        mag;
  logic [HI_W-1:0]         mag_hi;
  logic                    ovf_in;

  logic [DEN_W-1:0] rem_q [0:QB];
  logic [QB-1:0]    low_q [0:QB];
  logic [QB-1:0]    quo_q [0:QB];
  logic             neg_q [0:QB];
  logic             ovf_q [0:QB];

  // Magnitude plus half the divisor gives round half away from zero
  always_comb begin
    num_ext = MAG_W'(num);
    mag     = (num_ext[MAG_W-1] ? MAG_W'(-num_ext) : MAG_W'(num_ext)) + MAG_W'(den >> 1);
    mag_hi  = mag[MAG_W-1:QB];
    ovf_in  = CMP_W'(mag_hi) >= CMP_W'(den);
  end

  // Setup stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= DEN_W'(mag_hi);
      low_q[0] <= mag[QB-1:0];
      quo_q[0] <= '0;
      neg_q[0] <= num[NUM_W-1];
      ovf_q[0] <= ovf_in;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_bit
    logic [DEN_W:0]   trial;
    logic             take;
    logic [DEN_W-1:0] rem_nx;

    always_comb begin
      trial  = {rem_q[k-1], low_q[k-1][QB-1]};
      take   = trial >= {1'b0, den};
      rem_nx = take ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= rem_nx;
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QB-2:0], take};
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo = quo_q[QB];
  assign neg = neg_q[QB];
  assign ovf = ovf_q[QB];

endmodule

>>> rtl/sprite_quad_list_vertices.sv
// Rotated sprite quad vertex setup: one sprite word in, six vertex words out.
// Depends on sqlv_pkg and sqlv_div_lane.
//
// Each accepted sprite produces six vertices (corners 0,1,2,2,1,3), one per cycle while the
// output is not stalled, and a new sprite is taken as the last vertex of the previous one
// issues; the per-vertex pipeline runs through angle reduction, table lookup and rotation
// stages, then one divider lane stage per quotient bit, then the output skid register.
// Corners are rotated about the rectangle center with a quarter-wave sine ROM of
// 2^(SINE_TABLE_BITS-2)+1 entries, mapped to device coordinates and saturated; texture
// coordinates are the source edges over the texture size. The output has a skid register, so
// the pipeline keeps moving for one word after the sink stalls. Registers hold 0 as 1.
// Configuration writes are always ready and should be made while no sprite is in flight.
module sprite_quad_list_vertices #(
  parameter int SINE_TABLE_BITS = sqlv_pkg::SINE_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // dest_x, dest_y, dest_width, dest_height, src_x, src_y, src_width, src_height
  // (16 bits each), rgba [159:128], rotation [175:160]
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ndc_x [15:0], ndc_y [31:16], tex_u [47:32], tex_v [63:48], vertex_color [95:64]
  output logic [95:0]  m_axis_tdata,
  // vertex_slot [2:0]
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import sqlv_pkg::*;

  localparam int B      = SINE_TABLE_BITS;
  localparam int QTR    = 1 << (B - 2);
  localparam int ROM_W  = 15;
  localparam int AW     = 15 + B;
  localparam int SH     = AW + 16;
  localparam int RW     = SH - 14;
  localparam longint unsigned RECIP = (64'd1 << SH) / FULL_TURN;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam int GEO_LAST  = 7;
  localparam int LANE_BASE = 8;
  localparam int LAST      = LANE_BASE + QUO_BITS;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] QTR_L       = 64'(QTR);

  // ---------------- quarter-wave sine table, built at elaboration ----------------
  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = mulq30(x, x);
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - mulq30(x2, t) / 64'd42;
    t  = Q30_ONE - mulq30(x2, t) / 64'd20;
    t  = Q30_ONE - mulq30(x2, t) / 64'd6;
    return mulq30(x, t);
  endfunction

  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = mulq30(x, x);
    t  = Q30_ONE - x2 / 64'd56;
    t  = Q30_ONE - mulq30(x2, t) / 64'd30;
    t  = Q30_ONE - mulq30(x2, t) / 64'd12;
    t  = Q30_ONE - mulq30(x2, t) / 64'd2;
    return t;
  endfunction

  function automatic logic [63:0] quarter_sin(input logic [63:0] t);
    logic [63:0] x;
    logic [63:0] v;
    if (2 * t <= QTR_L) begin
      x = (t * Q30_HALF_PI + QTR_L / 2) / QTR_L;
      v = sin_q30(x);
    end else begin
      x = ((QTR_L - t) * Q30_HALF_PI + QTR_L / 2) / QTR_L;
      v = cos_q30(x);
    end
    return (v + 64'd32768) >> 16;
  endfunction

  function automatic logic [(QTR+1)*ROM_W-1:0] build_rom();
    logic [(QTR+1)*ROM_W-1:0] r;
    r = '0;
    for (int i = 0; i <= QTR; i++) begin
      r[i*ROM_W +: ROM_W] = ROM_W'(quarter_sin(64'(i)));
    end
    return r;
  endfunction

  localparam logic [(QTR+1)*ROM_W-1:0] SIN_ROM = build_rom();

  // ---------------- configuration registers ----------------
  logic [14:0] vp_w, vp_h, tex_w, tex_h;
  logic [14:0] vp_w_eff, vp_h_eff, tex_w_eff, tex_h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_w  <= VIEWPORT_WIDTH_RST;
      vp_h  <= VIEWPORT_HEIGHT_RST;
      tex_w <= TEXTURE_WIDTH_RST;
      tex_h <= TEXTURE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VIEWPORT_WIDTH:  vp_w  <= cfg_data[14:0];
        REG_VIEWPORT_HEIGHT: vp_h  <= cfg_data[14:0];
        REG_TEXTURE_WIDTH:   tex_w <= cfg_data[14:0];
        REG_TEXTURE_HEIGHT:  tex_h <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Zero divisor acts as one
  always_comb begin
    vp_w_eff  = (vp_w  == '0) ? 15'd1 : vp_w;
    vp_h_eff  = (vp_h  == '0) ? 15'd1 : vp_h;
    tex_w_eff = (tex_w == '0) ? 15'd1 : tex_w;
    tex_h_eff = (tex_h == '0) ? 15'd1 : tex_h;
  end

  // ---------------- output skid and pipeline enable ----------------
  logic        out_v, skid_v;
  logic        pipe_en;
  logic [99:0] fin_word, skid_word, out_word;   // {last, slot, tdata}
  logic        v [0:LAST];

  assign pipe_en = !skid_v;

  // ---------------- sprite issue: one vertex per cycle while pipe_en is high ----------------
  logic [175:0] spr;
  logic         busy;
  logic [2:0]   slot;

  assign s_axis_tready = !busy || (pipe_en && slot == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (busy && pipe_en) begin
      if (slot == LAST_SLOT) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      spr <= s_axis_tdata;
    end
  end

  // ---------------- stage 0: corner setup and angle reduction ----------------
  logic [1:0]          corner;
  logic signed [15:0]  dx, dy, dw, dh, sx, sy, sw, sh, rot;
  logic signed [16:0]  dw17, dh17, u_edge, v_edge;
  logic signed [17:0]  a1, a2, ang;
  geo_t                geo0;
  side_t               side0;
  logic [AW-1:0]       num0;

  always_comb begin
    corner = corner_of(slot);
    dx  = $signed(spr[15:0]);
    dy  = $signed(spr[31:16]);
    dw  = $signed(spr[47:32]);
    dh  = $signed(spr[63:48]);
    sx  = $signed(spr[79:64]);
    sy  = $signed(spr[95:80]);
    sw  = $signed(spr[111:96]);
    sh  = $signed(spr[127:112]);
    rot = $signed(spr[175:160]);
    dw17 = 17'(dw);
    dh17 = 17'(dh);
    geo0.ox  = corner[0] ? dw17 : -dw17;
    geo0.oy  = corner[1] ? dh17 : -dh17;
    geo0.cx5 = (18'(dx) <<< 1) + 18'(dw);
    geo0.cy5 = (18'(dy) <<< 1) + 18'(dh);
    u_edge   = corner[0] ? (17'(sx) + 17'(sw)) : 17'(sx);
    v_edge   = corner[1] ? (17'(sy) + 17'(sh)) : 17'(sy);
    geo0.un  = 25'(u_edge) <<< 8;
    geo0.vn  = 25'(v_edge) <<< 8;
    side0.color = spr[159:128];
    side0.slot  = slot;
    side0.last  = slot == LAST_SLOT;
    // rotation mod one turn, into 0..FULL_TURN-1
    a1  = 18'(rot) + (rot[15] ? 18'(FULL_TURN) : 18'sd0);
    a2  = a1 + (a1[17] ? 18'(FULL_TURN) : 18'sd0);
    ang = (a2 >= 18'(FULL_TURN)) ? a2 - 18'(FULL_TURN) : a2;
    num0 = {ang[14:0], {B{1'b0}}} + AW'(FULL_TURN / 2);
  end

  // ---------------- pipeline registers ----------------
  geo_t                geo_q  [0:GEO_LAST];
  side_t               side_q [0:LAST];
  logic [AW-1:0]       s0_num, s1_num, s2_num;
  logic [2*AW+1:0]     s1_prod;
  logic [B:0]          s2_q0;
  logic [B-1:0]        s3_idx;
  logic [1:0]          s4_quad;
  logic [ROM_W-1:0]    s4_s0, s4_c0;
  logic signed [15:0]  s5_s, s5_c;
  logic signed [32:0]  s6_cox, s6_soy, s6_sox, s6_coy;
  logic signed [XY_NUM_W-1:0] s7_x, s7_y;

  // Index correction: idx = round(ang * 2^B / FULL_TURN) via reciprocal
  logic [AW:0]        q0_turn, num_rem;
  logic [B:0]         q_fix;
  logic [B-2:0]       sin_addr, cos_addr;
  logic signed [15:0] s0_ext, c0_ext;

  always_comb begin
    q0_turn  = {{(AW-B){1'b0}}, s2_q0} * (AW+1)'(FULL_TURN);
    num_rem  = {1'b0, s2_num} - q0_turn;
    q_fix    = (num_rem >= (AW+1)'(FULL_TURN)) ? s2_q0 + (B+1)'(1) : s2_q0;
    sin_addr = {1'b0, s3_idx[B-3:0]};
    cos_addr = (B-1)'(QTR) - sin_addr;
    s0_ext   = $signed({1'b0, s4_s0});
    c0_ext   = $signed({1'b0, s4_c0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) v[k] <= 1'b0;
    end else if (pipe_en) begin
      v[0] <= busy;
      for (int k = 1; k <= LAST; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      geo_q[0]  <= geo0;
      side_q[0] <= side0;
      for (int k = 1; k <= GEO_LAST; k++) geo_q[k] <= geo_q[k-1];
      for (int k = 1; k <= LAST; k++) side_q[k] <= side_q[k-1];
      // stage 0 -> 1: reciprocal multiply
      s0_num  <= num0;
      s1_num  <= s0_num;
      s1_prod <= s0_num * RECIP_V;
      // stage 2: coarse quotient
      s2_num  <= s1_num;
      s2_q0   <= s1_prod[SH +: B+1];
      // stage 3: corrected table index
      s3_idx  <= q_fix[B-1:0];
      // stage 4: quarter-wave reads
      s4_quad <= s3_idx[B-1:B-2];
      s4_s0   <= SIN_ROM[sin_addr*ROM_W +: ROM_W];
      s4_c0   <= SIN_ROM[cos_addr*ROM_W +: ROM_W];
      // stage 5: quadrant fold
      case (s4_quad)
        2'd0: begin s5_s <= s0_ext;  s5_c <= c0_ext;  end
        2'd1: begin s5_s <= c0_ext;  s5_c <= -s0_ext; end
        2'd2: begin s5_s <= -s0_ext; s5_c <= -c0_ext; end
        default: begin s5_s <= -c0_ext; s5_c <= s0_ext; end
      endcase
      // stage 6: rotation products
      s6_cox <= s5_c * geo_q[5].ox;
      s6_soy <= s5_s * geo_q[5].oy;
      s6_sox <= s5_s * geo_q[5].ox;
      s6_coy <= s5_c * geo_q[5].oy;
      // stage 7: rotated corners in Q.19
      s7_x <= (XY_NUM_W'(geo_q[6].cx5) <<< 14) + XY_NUM_W'(s6_cox) - XY_NUM_W'(s6_soy);
      s7_y <= (XY_NUM_W'(geo_q[6].cy5) <<< 14) + XY_NUM_W'(s6_sox) + XY_NUM_W'(s6_coy);
    end
  end

  // ---------------- divider lanes ----------------
  logic [QUO_BITS-1:0] qx, qy, qu, qv;
  logic nx, ny, nu, nv, ox_f, oy_f, ou_f, ov_f;

  sqlv_div_lane #(.NUM_W(XY_NUM_W), .DEN_W(XY_DEN_W)) u_div_x (
    .clk(clk), .en(pipe_en), .num(s7_x), .den({vp_w_eff, 4'd0}),
    .quo(qx), .neg(nx), .ovf(ox_f)
  );
  sqlv_div_lane #(.NUM_W(XY_NUM_W), .DEN_W(XY_DEN_W)) u_div_y (
    .clk(clk), .en(pipe_en), .num(s7_y), .den({vp_h_eff, 4'd0}),
    .quo(qy), .neg(ny), .ovf(oy_f)
  );
  sqlv_div_lane #(.NUM_W(UV_NUM_W), .DEN_W(UV_DEN_W)) u_div_u (
    .clk(clk), .en(pipe_en), .num(geo_q[GEO_LAST].un), .den(tex_w_eff),
    .quo(qu), .neg(nu), .ovf(ou_f)
  );
  sqlv_div_lane #(.NUM_W(UV_NUM_W), .DEN_W(UV_DEN_W)) u_div_v (
    .clk(clk), .en(pipe_en), .num(geo_q[GEO_LAST].vn), .den(tex_h_eff),
    .quo(qv), .neg(nv), .ovf(ov_f)
  );

  // ---------------- device mapping and saturation ----------------
  logic signed [QUO_BITS+1:0] sqx, sqy, squ, sqv;
  logic [15:0] ndc_x, ndc_y, tex_u, tex_v;

  always_comb begin
    sqx   = signed_quo(qx, nx, ox_f);
    sqy   = signed_quo(qy, ny, oy_f);
    squ   = signed_quo(qu, nu, ou_f);
    sqv   = signed_quo(qv, nv, ov_f);
    ndc_x = sat16(32'(sqx) - 32'sd16384);
    ndc_y = sat16(32'sd16384 - 32'(sqy));
    tex_u = sat16(32'(squ));
    tex_v = sat16(32'(sqv));
    fin_word = {side_q[LAST].last, side_q[LAST].slot, side_q[LAST].color,
                tex_v, tex_u, ndc_y, ndc_x};
  end

  // ---------------- output register with skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_axis_tready) begin
      out_v  <= skid_v || (pipe_en && v[LAST]);
      skid_v <= 1'b0;
    end else if (pipe_en && v[LAST]) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_axis_tready) begin
      out_word <= skid_v ? skid_word : fin_word;
    end else if (pipe_en && v[LAST]) begin
      skid_word <= fin_word;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_word[95:0];
  assign m_axis_tuser  = out_word[98:96];
  assign m_axis_tlast  = out_word[99];

  // ---------------- checks ----------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid word held while output empty");

  a_last_on_slot5: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_SLOT)))
    else $error("last flag does not match vertex slot");

  a_ready_only_free: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!busy || (slot == LAST_SLOT && !skid_v)))
    else $error("sprite accepted while vertices still to issue");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (busy && slot == 3'd0))
    else $error("accepted sprite did not start at slot zero");

endmodule

>>> bench/sprite_quad_list_vertices_test.sv
// Self-checking bench for sprite_quad_list_vertices: directed sprite table, then random sprites.
// Depends on sqlv_pkg and the sprite_quad_list_vertices RTL.
module sprite_quad_list_vertices_test;
  import sqlv_pkg::*;

  localparam int TABLE_BITS = 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [15:0] ndc_x;
    logic [15:0] ndc_y;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [31:0] color;
    logic [2:0]  slot;
    logic        last;
  } vertex_t;

  typedef struct {
    logic [15:0] f[8];
    logic [31:0] rgba;
    logic [15:0] rot;
    bit          known;
    vertex_t     v0;
  } sprite_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [175:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  sprite_quad_list_vertices #(.SINE_TABLE_BITS(TABLE_BITS)) DUT (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers
  longint vp_w = 1280, vp_h = 720, tx_w = 256, tx_h = 256;

  vertex_t     vertex_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          long_hold = 1'b0;
  sprite_row_t dir_rows[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Q30 fixed-point sine/cosine on the first octant
  function automatic longint mul30(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint oct_sin(longint x);
    longint x2, t;
    x2 = mul30(x, x);
    t = 64'sd1073741824 - x2 / 72;
    t = 64'sd1073741824 - mul30(x2, t) / 42;
    t = 64'sd1073741824 - mul30(x2, t) / 20;
    t = 64'sd1073741824 - mul30(x2, t) / 6;
    return mul30(x, t);
  endfunction

  function automatic longint oct_cos(longint x);
    longint x2, t;
    x2 = mul30(x, x);
    t = 64'sd1073741824 - x2 / 56;
    t = 64'sd1073741824 - mul30(x2, t) / 30;
    t = 64'sd1073741824 - mul30(x2, t) / 12;
    t = 64'sd1073741824 - mul30(x2, t) / 2;
    return t;
  endfunction

  function automatic longint quarter_wave(longint t);
    longint q, x;
    q = 64'sd1 << (TABLE_BITS - 2);
    if (2 * t <= q) begin
      x = (t * 64'sd1686629713 + q / 2) / q;
      return (oct_sin(x) + (64'sd1 << 15)) >>> 16;
    end
    x = ((q - t) * 64'sd1686629713 + q / 2) / q;
    return (oct_cos(x) + (64'sd1 << 15)) >>> 16;
  endfunction

  function automatic longint div_round(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint nz(longint r);
    return (r == 0) ? 1 : r;
  endfunction

  // six expected vertices of one sprite
  task automatic predict_quad(input logic [175:0] w);
    longint dx, dy, dw, dh, sx, sy, sw, sh, a, idx, n, q, t, s0, c0, sn, cs;
    longint ox, oy, x19, y19, cx5, cy5;
    logic [15:0] px[4], py[4], uu[2], vv[2];
    int corner;
    vertex_t v;
    dx = $signed(w[15:0]);    dy = $signed(w[31:16]);
    dw = $signed(w[47:32]);   dh = $signed(w[63:48]);
    sx = $signed(w[79:64]);   sy = $signed(w[95:80]);
    sw = $signed(w[111:96]);  sh = $signed(w[127:112]);
    n = 64'sd1 << TABLE_BITS;
    q = 64'sd1 << (TABLE_BITS - 2);
    a = longint'($signed(w[175:160])) % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    idx = ((a * n + FULL_TURN / 2) / FULL_TURN) & (n - 1);
    t = idx & (q - 1);
    s0 = quarter_wave(t);
    c0 = quarter_wave(q - t);
    case (idx >> (TABLE_BITS - 2))
      0: begin sn = s0;  cs = c0;  end
      1: begin sn = c0;  cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
    cx5 = 2 * dx + dw;
    cy5 = 2 * dy + dh;
    for (int k = 0; k < 4; k++) begin
      ox = k[0] ? dw : -dw;
      oy = k[1] ? dh : -dh;
      x19 = cx5 * 16384 + cs * ox - sn * oy;
      y19 = cy5 * 16384 + sn * ox + cs * oy;
      px[k] = clamp16(div_round(x19, 16 * nz(vp_w)) - 16384);
      py[k] = clamp16(16384 - div_round(y19, 16 * nz(vp_h)));
    end
    uu[0] = clamp16(div_round(sx * 256, nz(tx_w)));
    uu[1] = clamp16(div_round((sx + sw) * 256, nz(tx_w)));
    vv[0] = clamp16(div_round(sy * 256, nz(tx_h)));
    vv[1] = clamp16(div_round((sy + sh) * 256, nz(tx_h)));
    for (int k = 0; k < 6; k++) begin
      corner = corner_of(3'(k));
      v.ndc_x = px[corner];
      v.ndc_y = py[corner];
      v.tex_u = uu[corner & 1];
      v.tex_v = vv[(corner >> 1) & 1];
      v.color = w[159:128];
      v.slot = 3'(k);
      v.last = (k == 5);
      vertex_q.insert(vertex_q.size(), v);
    end
  endtask

  // output checker and watchdog
  always @(posedge clk) begin
    vertex_t want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata[31:0], 0);
        end else begin
          want = vertex_q.pop_front();
          if (m_axis_tdata[15:0] !== want.ndc_x)
            report_mismatch("ndc_x", m_axis_tdata[15:0], want.ndc_x);
          if (m_axis_tdata[31:16] !== want.ndc_y)
            report_mismatch("ndc_y", m_axis_tdata[31:16], want.ndc_y);
          if (m_axis_tdata[47:32] !== want.tex_u)
            report_mismatch("tex_u", m_axis_tdata[47:32], want.tex_u);
          if (m_axis_tdata[63:48] !== want.tex_v)
            report_mismatch("tex_v", m_axis_tdata[63:48], want.tex_v);
          if (m_axis_tdata[95:64] !== want.color)
            report_mismatch("color", m_axis_tdata[95:64], want.color);
          if (m_axis_tuser !== want.slot)
            report_mismatch("slot", m_axis_tuser, want.slot);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end
    end
  end

  // sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (long_hold)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic hold_sink(input int cycles);
    long_hold = 1'b1;
    repeat (cycles) @(negedge clk);
    long_hold = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_VIEWPORT_WIDTH:  vp_w = val[14:0];
      REG_VIEWPORT_HEIGHT: vp_h = val[14:0];
      REG_TEXTURE_WIDTH:   tx_w = val[14:0];
      default:             tx_h = val[14:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one sprite word; holds valid until accepted
  task automatic send_sprite(input logic [175:0] w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= w;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_quad(w);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(2047));
      3: return -16'($urandom_range(2047));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [175:0] rand_sprite();
    logic [175:0] w;
    for (int i = 0; i < 8; i++) w[i*16 +: 16] = rand_field();
    w[159:128] = $urandom;
    w[175:160] = 16'($urandom_range(46079)) - 16'd23040;
    return w;
  endfunction

  function automatic sprite_row_t mk_row(input logic [15:0] a, input logic [15:0] b,
                                         input logic [31:0] rgba, input logic [15:0] rot);
    sprite_row_t r;
    for (int i = 0; i < 8; i++) r.f[i] = i[0] ? b : a;
    r.rgba = rgba;
    r.rot = rot;
    r.known = 1'b0;
    return r;
  endfunction

  initial begin
    sprite_row_t r;
    logic [175:0] w;
    logic [15:0] cfg_set[4][4];

    // directed: zero sprite at reset settings lands on device x=-1, y=+1, uv=0
    r = mk_row(16'h0000, 16'h0000, 32'h0, 16'h0);
    r.known = 1'b1;
    r.v0 = '{16'hc000, 16'h4000, 16'h0000, 16'h0000, 32'h0, 3'd0, 1'b0};
    dir_rows.insert(dir_rows.size(), r);
    dir_rows.insert(dir_rows.size(), mk_row(16'h7fff, 16'h7fff, 32'hffffffff, 16'h59ff));
    dir_rows.insert(dir_rows.size(), mk_row(16'h8000, 16'h8000, 32'h80000001, 16'ha600));
    dir_rows.insert(dir_rows.size(), mk_row(16'h8000, 16'h7fff, 32'h12345678, 16'd5760));
    dir_rows.insert(dir_rows.size(), mk_row(16'h0100, 16'hff00, 32'hdeadbeef, 16'd11520));
    dir_rows.insert(dir_rows.size(), mk_row(16'h0100, 16'h0200, 32'ha5a5a5a5, 16'd17280));
    dir_rows.insert(dir_rows.size(), mk_row(16'h0040, 16'h0400, 32'h5a5a5a5a, -16'd5760));
    dir_rows.insert(dir_rows.size(), mk_row(16'h0010, 16'h0800, 32'h0f0f0f0f, 16'd11));
    dir_rows.insert(dir_rows.size(), mk_row(16'h0010, 16'h0800, 32'hf0f0f0f0, 16'd12));
    dir_rows.insert(dir_rows.size(), mk_row(16'h1000, 16'hf800, 32'h00ff00ff, 16'd2880));
    dir_rows.insert(dir_rows.size(), mk_row(16'h0000, 16'h0000, 32'h0, -16'd1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      w = {dir_rows[i].rot, dir_rows[i].rgba, dir_rows[i].f[7], dir_rows[i].f[6],
           dir_rows[i].f[5], dir_rows[i].f[4], dir_rows[i].f[3], dir_rows[i].f[2],
           dir_rows[i].f[1], dir_rows[i].f[0]};
      send_sprite(w);
      if (dir_rows[i].known && vertex_q[vertex_q.size() - 6] !== dir_rows[i].v0)
        report_mismatch("table row", i, 0);
    end
    wait_drained();

    // settings: small, large, zero (acts as one) beside full scale, mixed; every register each phase
    cfg_set = '{'{16'd1, 16'd1, 16'd1, 16'd1},
                '{16'd16384, 16'd16384, 16'd16384, 16'd16384},
                '{16'd0, 16'hffff, 16'd0, 16'h7fff},
                '{16'd640, 16'd480, 16'd64, 16'd32}};

    for (int phase = 0; phase < 4; phase++) begin
      foreach (cfg_set[phase][j]) write_reg(cfg_reg_t'(j), cfg_set[phase][j]);
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < 110; i++) begin
        if (phase == 2 && i == 10) begin
          fork
            hold_sink(300);
          join_none
        end
        // pause until every vertex is out
        if (phase == 3 && i == 55) wait_drained();
        send_sprite(rand_sprite());
      end
      wait_drained();
    end

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
